/* rtl/core/text_console_cell_engine_assert.svh */
// assertion macros for the text console cell engine
// used by modules that check their own control logic; clock i_clk, reset i_rst_n
`ifndef TEXT_CONSOLE_CELL_ENGINE_ASSERT_SVH
`define TEXT_CONSOLE_CELL_ENGINE_ASSERT_SVH
`ifndef SYNTHESIS
// checked property, disabled while reset is low
`define CCE_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("cce assertion failed");
// checked property, also checked during reset
`define CCE_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("cce assertion failed");
`else
`define CCE_ASSERT(lbl, prop)
`define CCE_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

/* rtl/core/cce_pkg.sv */
// shared types and constants of the text console cell engine
// no dependencies
package cce_pkg;

    localparam int POS_W  = 11;
    localparam int CELL_W = 16;
    localparam int ADDR_W = 11;

    localparam logic [7:0]  CH_TAB      = 8'd9;
    localparam logic [7:0]  CH_NEWLINE  = 8'd10;
    localparam logic [7:0]  CH_RETURN   = 8'd13;
    localparam logic [7:0]  CH_SPACE    = 8'd32;
    localparam logic [7:0]  RESET_ATTR  = 8'h07;
    localparam logic [15:0] BLANK_RESET = {RESET_ATTR, CH_SPACE};

    typedef enum logic [1:0] {
        ACT_PUT       = 2'd0,
        ACT_BACKSPACE = 2'd1,
        ACT_CLEAR     = 2'd2,
        ACT_READ      = 2'd3
    } t_cce_action;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_RDWAIT,
        ST_PUT,
        ST_COPY,
        ST_FILL,
        ST_CLEAR,
        ST_DONE
    } t_cce_state;

    typedef struct packed {
        logic              valid;
        logic [POS_W-1:0]  cursor_position;
        logic [CELL_W-1:0] cell_value;
    } t_cce_res;

endpackage

/* rtl/core/cce_if.sv */
// valid/ready channel interfaces for the console command and result words
// depends on cce_pkg for field widths
interface cce_in_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 action;
    logic [7:0]                 char_code;
    logic [cce_pkg::ADDR_W-1:0] cell_address;

    modport source (output valid, action, char_code, cell_address, input ready);
    modport sink   (input valid, action, char_code, cell_address, output ready);
endinterface

interface cce_out_if;
    logic                       valid;
    logic                       ready;
    logic [cce_pkg::POS_W-1:0]  cursor_position;
    logic [cce_pkg::CELL_W-1:0] cell_value;

    modport source (output valid, cursor_position, cell_value, input ready);
    modport sink   (input valid, cursor_position, cell_value, output ready);
endinterface

/* rtl/core/cce_cell_ram.sv */
// screen cell memory: one write port, one read port, registered read data
// no dependencies
module cce_cell_ram #(
    parameter int DEPTH = 2000,
    parameter int AW    = 11,
    parameter int DW    = 16
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/cce_ctrl.sv */
// console sequencer: cursor, command decode, scroll/clear sweeps over the cell memory
// depends on cce_pkg, cce_if and text_console_cell_engine_assert.svh
`include "text_console_cell_engine_assert.svh"

module cce_ctrl #(
    parameter int COLUMNS    = 80,
    parameter int ROWS       = 25,
    parameter int TAB_SPACES = 4,
    parameter int AW         = 11
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    cce_in_if.sink                     i_in,
    input  logic [7:0]                 i_attr,
    output cce_pkg::t_cce_res          o_res,
    input  logic                       i_res_ready,
    output logic                       o_mem_we,
    output logic [AW-1:0]              o_mem_waddr,
    output logic [cce_pkg::CELL_W-1:0] o_mem_wdata,
    output logic [AW-1:0]              o_mem_raddr,
    input  logic [cce_pkg::CELL_W-1:0] i_mem_rdata
);

    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int RW = $clog2(ROWS);
    localparam int CW = $clog2(COLUMNS);
    localparam int TW = $clog2(TAB_SPACES + 1);

    localparam logic [AW-1:0] LAST_BASE = AW'((ROWS - 1) * COLUMNS);
    localparam logic [AW-1:0] LAST_CELL = AW'(CELL_COUNT - 1);
    localparam logic [AW-1:0] COLS_A    = AW'(COLUMNS);
    localparam logic [CW-1:0] LAST_COL  = CW'(COLUMNS - 1);
    localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);

    cce_pkg::t_cce_state  r_state, n_state;
    cce_pkg::t_cce_action r_action, n_action;
    logic [RW-1:0]        r_row, n_row;
    logic [CW-1:0]        r_col, n_col;
    logic [AW-1:0]        r_pos, n_pos;
    logic [AW-1:0]        r_idx, n_idx;
    logic [AW-1:0]        r_widx, n_widx;
    logic                 r_wpend, n_wpend;
    logic [TW-1:0]        r_tab, n_tab;
    logic [7:0]           r_char, n_char;
    logic [cce_pkg::ADDR_W-1:0] r_addr, n_addr;
    logic [cce_pkg::CELL_W-1:0] r_value, n_value;
    logic                 in_ready;
    logic                 res_valid;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cce_pkg::ST_INIT;
            r_row   <= '0;
            r_col   <= '0;
            r_pos   <= '0;
            r_idx   <= '0;
            r_wpend <= 1'b0;
            r_tab   <= '0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_col   <= n_col;
            r_pos   <= n_pos;
            r_idx   <= n_idx;
            r_wpend <= n_wpend;
            r_tab   <= n_tab;
        end
    end

    // payload registers of the word in flight
    always_ff @(posedge i_clk) begin
        r_action <= n_action;
        r_char   <= n_char;
        r_addr   <= n_addr;
        r_value  <= n_value;
        r_widx   <= n_widx;
    end

    // next state and memory port control
    always_comb begin
        n_state     = r_state;
        n_action    = r_action;
        n_row       = r_row;
        n_col       = r_col;
        n_pos       = r_pos;
        n_idx       = r_idx;
        n_widx      = r_widx;
        n_wpend     = 1'b0;
        n_tab       = r_tab;
        n_char      = r_char;
        n_addr      = r_addr;
        n_value     = r_value;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_pos;
        o_mem_wdata = {i_attr, cce_pkg::CH_SPACE};
        o_mem_raddr = AW'(r_idx + COLS_A);
        in_ready    = 1'b0;
        res_valid   = 1'b0;

        case (r_state)
            // clearing pass after reset
            cce_pkg::ST_INIT: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_idx;
                o_mem_wdata = cce_pkg::BLANK_RESET;
                if (r_idx == LAST_CELL) begin
                    n_idx   = '0;
                    n_state = cce_pkg::ST_IDLE;
                end else begin
                    n_idx = AW'(r_idx + 1'b1);
                end
            end

            cce_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (i_in.valid) begin
                    n_action = cce_pkg::t_cce_action'(i_in.action);
                    n_char   = i_in.char_code;
                    n_addr   = i_in.cell_address;
                    n_state  = cce_pkg::ST_EXEC;
                end
            end

            // decode the command word
            cce_pkg::ST_EXEC: begin
                n_value = '0;
                case (r_action)
                    cce_pkg::ACT_PUT: begin
                        case (r_char)
                            cce_pkg::CH_NEWLINE: begin
                                n_col = '0;
                                n_tab = '0;
                                if (r_row == LAST_ROW) begin
                                    n_pos   = LAST_BASE;
                                    n_idx   = '0;
                                    n_state = cce_pkg::ST_COPY;
                                end else begin
                                    n_row   = RW'(r_row + 1'b1);
                                    n_pos   = AW'(r_pos - AW'(r_col) + COLS_A);
                                    n_state = cce_pkg::ST_DONE;
                                end
                            end
                            cce_pkg::CH_RETURN: begin
                                n_col   = '0;
                                n_pos   = AW'(r_pos - AW'(r_col));
                                n_state = cce_pkg::ST_DONE;
                            end
                            cce_pkg::CH_TAB: begin
                                n_char  = cce_pkg::CH_SPACE;
                                n_tab   = TW'(TAB_SPACES);
                                n_state = cce_pkg::ST_PUT;
                            end
                            default: begin
                                n_tab   = TW'(1);
                                n_state = cce_pkg::ST_PUT;
                            end
                        endcase
                    end
                    cce_pkg::ACT_BACKSPACE: begin
                        // nothing happens at the origin
                        if (r_pos != '0) begin
                            n_pos = AW'(r_pos - 1'b1);
                            if (r_col == '0) begin
                                n_row = RW'(r_row - 1'b1);
                                n_col = LAST_COL;
                            end else begin
                                n_col = CW'(r_col - 1'b1);
                            end
                            o_mem_we    = 1'b1;
                            o_mem_waddr = AW'(r_pos - 1'b1);
                        end
                        n_state = cce_pkg::ST_DONE;
                    end
                    cce_pkg::ACT_CLEAR: begin
                        n_row   = '0;
                        n_col   = '0;
                        n_pos   = '0;
                        n_idx   = '0;
                        n_state = cce_pkg::ST_CLEAR;
                    end
                    cce_pkg::ACT_READ: begin
                        // addresses beyond the store read as zero
                        if (32'(r_addr) < CELL_COUNT) begin
                            o_mem_raddr = AW'(r_addr);
                            n_state     = cce_pkg::ST_RDWAIT;
                        end else begin
                            n_state = cce_pkg::ST_DONE;
                        end
                    end
                    default: begin
                        n_state = cce_pkg::ST_DONE;
                    end
                endcase
            end

            cce_pkg::ST_RDWAIT: begin
                n_value = i_mem_rdata;
                n_state = cce_pkg::ST_DONE;
            end

            // write one character and advance the cursor
            cce_pkg::ST_PUT: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_pos;
                o_mem_wdata = {i_attr, r_char};
                n_tab       = TW'(r_tab - 1'b1);
                n_state     = (r_tab == TW'(1)) ? cce_pkg::ST_DONE : cce_pkg::ST_PUT;
                if (r_col == LAST_COL) begin
                    n_col = '0;
                    if (r_row == LAST_ROW) begin
                        n_pos   = LAST_BASE;
                        n_idx   = '0;
                        n_state = cce_pkg::ST_COPY;
                    end else begin
                        n_row = RW'(r_row + 1'b1);
                        n_pos = AW'(r_pos + 1'b1);
                    end
                end else begin
                    n_col = CW'(r_col + 1'b1);
                    n_pos = AW'(r_pos + 1'b1);
                end
            end

            // scroll: read one row ahead, write back the word read last cycle
            cce_pkg::ST_COPY: begin
                o_mem_raddr = AW'(r_idx + COLS_A);
                o_mem_we    = r_wpend;
                o_mem_waddr = r_widx;
                o_mem_wdata = i_mem_rdata;
                if (r_idx == LAST_BASE) begin
                    n_state = cce_pkg::ST_FILL;
                end else begin
                    n_wpend = 1'b1;
                    n_widx  = r_idx;
                    n_idx   = AW'(r_idx + 1'b1);
                end
            end

            // blank the bottom row, then resume a pending tab
            cce_pkg::ST_FILL: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_idx;
                if (r_idx == LAST_CELL) begin
                    n_idx   = '0;
                    n_state = (r_tab == '0) ? cce_pkg::ST_DONE : cce_pkg::ST_PUT;
                end else begin
                    n_idx = AW'(r_idx + 1'b1);
                end
            end

            cce_pkg::ST_CLEAR: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_idx;
                if (r_idx == LAST_CELL) begin
                    n_idx   = '0;
                    n_state = cce_pkg::ST_DONE;
                end else begin
                    n_idx = AW'(r_idx + 1'b1);
                end
            end

            cce_pkg::ST_DONE: begin
                res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = cce_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = cce_pkg::ST_IDLE;
            end
        endcase
    end

    assign i_in.ready            = in_ready;
    assign o_res.valid           = res_valid;
    assign o_res.cursor_position = cce_pkg::POS_W'(r_pos);
    assign o_res.cell_value      = r_value;

    // linear cursor tracks row and column
    `CCE_ASSERT(a_pos_consistent,
        32'(r_pos) == 32'(r_row) * COLUMNS + 32'(r_col))
    `CCE_ASSERT(a_cursor_in_range,
        (32'(r_row) < ROWS) && (32'(r_col) < COLUMNS))
    `CCE_ASSERT(a_write_in_range, o_mem_we |-> (32'(o_mem_waddr) < CELL_COUNT))
    `CCE_ASSERT(a_value_zero_unless_read,
        (o_res.valid && (r_action != cce_pkg::ACT_READ)) |-> (o_res.cell_value == '0))
    `CCE_ASSERT(a_accept_decodes, (i_in.valid && i_in.ready) |=> (r_state == cce_pkg::ST_EXEC))

endmodule

/* rtl/core/text_console_cell_engine.sv */
// text console cell engine, top level: attribute register, result register,
// sequencer and cell memory; depends on cce_pkg, cce_if, cce_ctrl, cce_cell_ram
//
// Usage:
//   i_in   carries command words (action, char_code, cell_address), valid/ready.
//   o_out  returns one result word per command (cursor_position, cell_value).
//   i_cfg_we / i_cfg_data write the attribute used for written and blank cells;
//   write it only while no command is outstanding.
// Operation (COLUMNS x ROWS cells, N = ROWS*COLUMNS):
//   one command at a time. A read waits for the registered read data of the memory;
//   a put or tab writes one cell per character. A scroll copies N - COLUMNS
//   cells, then blanks COLUMNS cells; a clear blanks all N cells. All these
//   sweeps go through the single write port of the memory. The next command
//   is taken in the cycle after the result leaves the sequencer.
// Reset: i_rst_n low for one edge; afterwards a clearing pass over all N cells
//   writes blank grey cells while i_in.ready stays low.
// Stall: a result waits in the output register; the sequencer can accept and
//   work the next command, but holds its result until the register frees.
module text_console_cell_engine #(
    parameter int COLUMNS    = 80,
    parameter int ROWS       = 25,
    parameter int TAB_SPACES = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cce_in_if.sink     i_in,
    cce_out_if.source  o_out,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data
);

    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int AW         = $clog2(CELL_COUNT);

    logic [7:0]                 r_attr;
    logic                       r_ovalid;
    logic [cce_pkg::POS_W-1:0]  r_ocur;
    logic [cce_pkg::CELL_W-1:0] r_ocell;
    cce_pkg::t_cce_res          res;
    logic                       res_ready;
    logic                       mem_we;
    logic [AW-1:0]              mem_waddr;
    logic [cce_pkg::CELL_W-1:0] mem_wdata;
    logic [AW-1:0]              mem_raddr;
    logic [cce_pkg::CELL_W-1:0] mem_rdata;

    // attribute register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= cce_pkg::RESET_ATTR;
        end else if (i_cfg_we) begin
            r_attr <= i_cfg_data;
        end
    end

    // output word register
    assign res_ready = !r_ovalid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (res.valid && res_ready) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.valid && res_ready) begin
            r_ocur  <= res.cursor_position;
            r_ocell <= res.cell_value;
        end
    end

    assign o_out.valid           = r_ovalid;
    assign o_out.cursor_position = r_ocur;
    assign o_out.cell_value      = r_ocell;

    // sequencer
    cce_ctrl #(
        .COLUMNS    (COLUMNS),
        .ROWS       (ROWS),
        .TAB_SPACES (TAB_SPACES),
        .AW         (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_attr      (r_attr),
        .o_res       (res),
        .i_res_ready (res_ready),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    // cell memory
    cce_cell_ram #(
        .DEPTH (CELL_COUNT),
        .AW    (AW),
        .DW    (cce_pkg::CELL_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

endmodule

/* verif/console_screen_checker.sv */
// result checker for the text console cell engine: keeps its own copy of the
// screen, cursor and attribute, predicts each result word and compares it
// depends on cce_pkg and the cce_in_if / cce_out_if channel interfaces
module console_screen_checker
    import cce_pkg::*;
#(
    parameter int COLUMNS    = 80,
    parameter int ROWS       = 25,
    parameter int TAB_SPACES = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cce_in_if          i_cmd,
    cce_out_if         i_res,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic [POS_W-1:0]  cursor_position;
        logic [CELL_W-1:0] cell_value;
    } t_screen_reply;

    // mirrored screen state
    logic [CELL_W-1:0] screen_copy [CELL_COUNT];
    int unsigned       row_now;
    int unsigned       col_now;
    logic [7:0]        attr_now;

    t_screen_reply replies_due [$];
    int            fail_total    = 0;
    int            checked_total = 0;

    function automatic logic [CELL_W-1:0] blank_cell();
        return {attr_now, CH_SPACE};
    endfunction

    function automatic void fill_screen(input logic [CELL_W-1:0] value);
        for (int i = 0; i < CELL_COUNT; i++)
            screen_copy[i] = value;
    endfunction

    // column 0 of the next row, scrolling up one row past the bottom
    function automatic void next_row();
        col_now = 0;
        row_now++;
        if (row_now >= ROWS) begin
            for (int i = 0; i < CELL_COUNT - COLUMNS; i++)
                screen_copy[i] = screen_copy[i + COLUMNS];
            for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++)
                screen_copy[i] = blank_cell();
            row_now = ROWS - 1;
        end
    endfunction

    // ordinary byte at the cursor, advance with line wrap
    function automatic void write_glyph(input logic [7:0] ch);
        screen_copy[row_now * COLUMNS + col_now] = {attr_now, ch};
        col_now++;
        if (col_now >= COLUMNS)
            next_row();
    endfunction

    // apply one command word to the mirror and return the result it causes
    function automatic t_screen_reply apply_command(input logic [1:0]        act_bits,
                                                    input logic [7:0]        ch,
                                                    input logic [ADDR_W-1:0] addr);
        t_screen_reply reply;
        reply.cell_value = '0;
        case (t_cce_action'(act_bits))
            ACT_PUT: begin
                if (ch == CH_NEWLINE)
                    next_row();
                else if (ch == CH_RETURN)
                    col_now = 0;
                else if (ch == CH_TAB)
                    for (int k = 0; k < TAB_SPACES; k++)
                        write_glyph(CH_SPACE);
                else
                    write_glyph(ch);
            end
            ACT_BACKSPACE: begin
                // nothing happens at the origin
                if (row_now != 0 || col_now != 0) begin
                    if (col_now == 0) begin
                        row_now--;
                        col_now = COLUMNS - 1;
                    end else begin
                        col_now--;
                    end
                    screen_copy[row_now * COLUMNS + col_now] = blank_cell();
                end
            end
            ACT_CLEAR: begin
                fill_screen(blank_cell());
                row_now = 0;
                col_now = 0;
            end
            ACT_READ: begin
                // addresses past the store read as zero
                if (addr < CELL_COUNT)
                    reply.cell_value = screen_copy[addr];
            end
            default: ;
        endcase
        reply.cursor_position = POS_W'(row_now * COLUMNS + col_now);
        return reply;
    endfunction

    // watch both channels and the attribute port
    always @(posedge i_clk) begin
        t_screen_reply got;
        t_screen_reply want;
        if (!i_rst_n) begin
            fill_screen(BLANK_RESET);
            row_now  = 0;
            col_now  = 0;
            attr_now = RESET_ATTR;
            replies_due.delete();
        end else begin
            if (i_cfg_we)
                attr_now = i_cfg_data;

            // result word against the oldest prediction
            if (i_res.valid && i_res.ready) begin
                got.cursor_position = i_res.cursor_position;
                got.cell_value      = i_res.cell_value;
                if (replies_due.size() == 0) begin
                    fail_total++;
                    if (fail_total <= REPORT_MAX)
                        $display("unexpected result word: cursor %0d cell 0x%04h",
                                 got.cursor_position, got.cell_value);
                end else begin
                    want = replies_due.pop_front();
                    checked_total++;
                    if (got !== want) begin
                        fail_total++;
                        if (fail_total <= REPORT_MAX)
                            $display({"result word %0d mismatch: cursor exp %0d got %0d, ",
                                      "cell exp 0x%04h got 0x%04h"},
                                     checked_total, want.cursor_position,
                                     got.cursor_position, want.cell_value, got.cell_value);
                    end
                end
            end

            // command word accepted: predict its result
            if (i_cmd.valid && i_cmd.ready)
                replies_due.push_back(apply_command(i_cmd.action, i_cmd.char_code,
                                                    i_cmd.cell_address));
        end
        o_fail_count <= fail_total;
        o_pending    <= replies_due.size();
        o_checked    <= checked_total;
    end

endmodule

/* verif/tb_text_console_cell_engine.sv */
// testbench top for the text console cell engine: clock, reset, command
// stimulus, result-side back-pressure and the verdict
// depends on cce_pkg, cce_if, the engine rtl and console_screen_checker
module tb_text_console_cell_engine;
    timeunit 1ns;
    timeprecision 1ps;
    import cce_pkg::*;

    localparam int CELL_COUNT   = 80 * 25;
    localparam int LIMIT_CYCLES = 3_000_000;
    localparam int LONG_HOLD    = 400;
    localparam int SETTLE       = 8;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       cfg_we;
    logic [7:0] cfg_data;

    bit         idle_on     = 1'b1;
    bit         stall_armed = 1'b0;
    bit         stall_done  = 1'b0;
    int         words_sent  = 0;
    int         cycle_count = 0;
    int         fail_count;
    int         pending;
    int         checked;
    logic [7:0] attr_pick;

    cce_in_if  cmd_if ();
    cce_out_if res_if ();

    text_console_cell_engine i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (cmd_if),
        .o_out      (res_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data)
    );

    console_screen_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd_if),
        .i_res        (res_if),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always #1 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
            $display("status: fail");
            $finish;
        end
    end

    // result side: short random stalls, one long hold on request
    initial begin
        forever begin
            if (stall_armed && !stall_done) begin
                res_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                stall_done = 1'b1;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
            end else begin
                res_if.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // offer one command word, leave valid high after it is taken
    task automatic send_word(input t_cce_action act, input logic [7:0] ch,
                             input logic [ADDR_W-1:0] addr);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            cmd_if.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        cmd_if.valid        <= 1'b1;
        cmd_if.action       <= act;
        cmd_if.char_code    <= ch;
        cmd_if.cell_address <= addr;
        words_sent++;
        do @(posedge i_clk); while (!cmd_if.ready);
    endtask

    task automatic put_byte(input logic [7:0] ch);
        send_word(ACT_PUT, ch, ADDR_W'($urandom));
    endtask

    task automatic erase_back();
        send_word(ACT_BACKSPACE, 8'($urandom), ADDR_W'($urandom));
    endtask

    task automatic read_cell(input logic [ADDR_W-1:0] addr);
        send_word(ACT_READ, 8'($urandom), addr);
    endtask

    // stop offering and wait until every result word is back
    task automatic drain_results();
        cmd_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_attribute(input logic [7:0] value);
        drain_results();
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    // mostly text lines and newlines, with edits, clears, reads and stray bytes
    task automatic random_traffic(input int count);
        int stop_at;
        int pick;
        int run_len;
        int spot;
        stop_at = words_sent + count;
        while (words_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(76, 84)
                                                      : $urandom_range(1, 6);
                repeat (run_len) put_byte(8'($urandom_range(0, 255)));
                put_byte(($urandom_range(0, 2) == 0) ? CH_RETURN : CH_NEWLINE);
            end else if (pick < 55) begin
                repeat ($urandom_range(1, 4)) put_byte(CH_NEWLINE);
            end else if (pick < 63) begin
                put_byte(CH_TAB);
            end else if (pick < 75) begin
                repeat ($urandom_range(1, 3)) erase_back();
            end else if (pick < 78) begin
                send_word(ACT_CLEAR, 8'($urandom), ADDR_W'($urandom));
            end else begin
                spot = $urandom_range(0, 9);
                if (spot == 0)
                    read_cell(ADDR_W'($urandom_range(CELL_COUNT, 2047)));
                else if (spot < 4)
                    read_cell(ADDR_W'($urandom_range(CELL_COUNT - 80, CELL_COUNT - 1)));
                else
                    read_cell(ADDR_W'($urandom_range(0, CELL_COUNT - 1)));
            end
        end
    endtask

    // main sequence
    initial begin
        i_rst_n             <= 1'b0;
        cmd_if.valid        <= 1'b0;
        cmd_if.action       <= ACT_PUT;
        cmd_if.char_code    <= '0;
        cmd_if.cell_address <= '0;
        cfg_we              <= 1'b0;
        cfg_data            <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed words under the reset attribute
        read_cell(ADDR_W'(0));
        read_cell(ADDR_W'(CELL_COUNT - 1));
        read_cell(ADDR_W'(CELL_COUNT));
        read_cell(11'h7FF);
        erase_back();                   // at the origin
        put_byte(8'h00);
        put_byte(8'hFF);
        put_byte(8'h08);                // other control byte, written as text
        put_byte(CH_TAB);
        put_byte(CH_RETURN);
        put_byte(CH_NEWLINE);
        erase_back();                   // crosses back to the end of row 0
        read_cell(ADDR_W'(79));
        put_byte(8'h41);                // last column, wraps to the next row
        read_cell(ADDR_W'(0));
        read_cell(ADDR_W'(4));
        read_cell(ADDR_W'(79));
        send_word(ACT_CLEAR, 8'hFF, 11'h7FF);
        read_cell(ADDR_W'(0));

        write_attribute(8'hFF);
        random_traffic(30);

        // long hold on the result side while words keep coming
        stall_armed = 1'b1;
        repeat (3) begin
            put_byte(8'($urandom_range(33, 126)));
            read_cell(ADDR_W'($urandom_range(0, CELL_COUNT - 1)));
        end
        drain_results();

        // push the cursor past the bottom row so that the screen scrolls
        write_attribute(8'h00);
        for (int k = 0; k < 26; k++) begin
            if (k % 4 == 0)
                put_byte(8'($urandom_range(33, 126)));
            put_byte(CH_NEWLINE);
        end
        random_traffic(25);

        // last part at full rate
        attr_pick = 8'($urandom_range(1, 254));
        write_attribute(attr_pick);
        idle_on = 1'b0;
        random_traffic(20);
        drain_results();

        $display("sent %0d command words: text, tabs, wrap, scroll, backspace, clear, reads",
                 words_sent);
        $display("checked %0d result words under attributes 0x07, 0xff, 0x00, 0x%02h",
                 checked, attr_pick);
        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/cce_pkg.sv
rtl/core/cce_if.sv
rtl/core/cce_cell_ram.sv
rtl/core/cce_ctrl.sv
rtl/core/text_console_cell_engine.sv
verif/console_screen_checker.sv
verif/tb_text_console_cell_engine.sv
